FILE: design/sbda_pkg.sv
// Package with shared constants and types for the signed binary to decimal ASCII converter.
package sbda_pkg;

	localparam int VALUE_W       = 64;
	localparam int DIGITS        = 20;
	localparam int DIG_IDX_W     = $clog2(DIGITS);
	localparam int BCD_W         = DIGITS * 4;
	localparam int BITS_PER_STEP = 4;
	localparam int STEPS         = VALUE_W / BITS_PER_STEP;
	localparam int STEP_CNT_W    = $clog2(STEPS);

	localparam logic [7:0] ASCII_ZERO  = 8'd48;
	localparam logic [7:0] ASCII_MINUS = 8'd45;
	localparam logic [3:0] BCD_LIMIT   = 4'd5;
	localparam logic [3:0] BCD_ADJUST  = 4'd3;

	typedef logic [DIGITS-1:0][3:0] bcd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_SIGN,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} dabble_status_t;

endpackage

FILE: design/signed_binary_to_decimal_ascii.sv
// Top level of the signed 64-bit integer to decimal ASCII text converter.
//
// Input channel: value with in_valid / in_stall. One beat carries one signed
// 64-bit integer. in_stall is high from the accepted beat until the last
// character of that value has been loaded into the output register.
// Output channel: char_code and last_char with out_valid / out_stall. One beat
// carries one ASCII character, most significant first: '-' for a negative
// value, then the digits without leading zeros; last_char marks the final one.
// Timing: the shift-and-add-3 unit handles four magnitude bits per cycle;
// after conversion the sequencer locates the leading digit, then emits
// one character per cycle while the receiver takes them. An item carries
// 1 to 20 characters.
// A stalled output beat holds in the output register and pauses emission.
// Reset clears the sequencer and the output valid; no item is kept.
module signed_binary_to_decimal_ascii
	import sbda_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic signed [VALUE_W-1:0] value,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [7:0]                char_code,
	output logic                      last_char
);

	state_t                state_q;
	state_t                state_d;
	logic                  neg_q;
	logic [DIG_IDX_W-1:0]  idx_q;
	logic                  out_valid_q;
	logic [7:0]            char_q;
	logic                  last_q;

	logic                  accept;
	logic                  load_ok;
	logic [VALUE_W-1:0]    mag;
	dabble_status_t        dbl_status;
	bcd_t                  bcd;
	logic [DIG_IDX_W-1:0]  lead;

	logic                  ld;
	logic [7:0]            ld_char;
	logic                  ld_last;
	logic                  idx_set;
	logic                  idx_dec;

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;
	assign load_ok  = !out_valid_q || !out_stall;
	assign mag      = value[VALUE_W-1] ? (~value) + 1'b1 : value;

	sbda_dabble u_dabble (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept),
		.mag    (mag),
		.status (dbl_status),
		.bcd    (bcd)
	);

	always_comb begin
		lead = '0;
		for (int i = 0; i < DIGITS; i++) begin
			if (bcd[i] != 4'd0) begin
				lead = DIG_IDX_W'(i);
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_CONV;
				end
			end
			ST_CONV: begin
				if (dbl_status.done) begin
					state_d = neg_q ? ST_SIGN : ST_EMIT;
				end
			end
			ST_SIGN: begin
				if (load_ok) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (load_ok && idx_q == '0) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		ld      = 1'b0;
		ld_char = ASCII_ZERO;
		ld_last = 1'b0;
		idx_set = 1'b0;
		idx_dec = 1'b0;
		unique case (state_q)
			ST_IDLE: ;
			ST_CONV: begin
				idx_set = dbl_status.done;
			end
			ST_SIGN: begin
				ld      = load_ok;
				ld_char = ASCII_MINUS;
			end
			ST_EMIT: begin
				ld      = load_ok;
				ld_char = ASCII_ZERO + {4'd0, bcd[idx_q]};
				ld_last = (idx_q == '0);
				idx_dec = load_ok && (idx_q != '0);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ld) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			neg_q <= value[VALUE_W-1];
		end
		if (idx_set) begin
			idx_q <= lead;
		end else if (idx_dec) begin
			idx_q <= idx_q - 1'b1;
		end
		if (ld) begin
			char_q <= ld_char;
			last_q <= ld_last;
		end
	end

	assign out_valid = out_valid_q;
	assign char_code = char_q;
	assign last_char = last_q;

`ifndef SYNTH
	a_done_in_conv: assert property (@(posedge clk) disable iff (!arst_n)
		dbl_status.done |-> state_q == ST_CONV)
		else $error("conversion finished outside the conversion state");

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> dbl_status.busy && state_q == ST_CONV)
		else $error("accepted beat did not start the conversion unit");

	a_char_legal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (char_code == ASCII_MINUS && !last_char) ||
			(char_code >= ASCII_ZERO && char_code <= ASCII_ZERO + 8'd9))
		else $error("output beat carries an illegal character");

	a_sign_then_digit: assert property (@(posedge clk) disable iff (!arst_n)
		ld && state_q == ST_SIGN |=> state_q == ST_EMIT)
		else $error("minus sign not followed by digit emission");
`endif

endmodule

FILE: design/sbda_dabble.sv
// Iterative shift-and-add-3 unit turning a 64-bit magnitude into 20 BCD digits.
module sbda_dabble
	import sbda_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [VALUE_W-1:0]   mag,
	output dabble_status_t       status,
	output bcd_t                 bcd
);

	logic [VALUE_W-1:0]    bin_q;
	logic [BCD_W-1:0]      bcd_q;
	logic [STEP_CNT_W-1:0] cnt_q;
	logic                  busy_q;
	logic                  done_q;

	logic [VALUE_W-1:0]    bin_d;
	logic [BCD_W-1:0]      bcd_d;

	always_comb begin
		bin_d = bin_q;
		bcd_d = bcd_q;
		for (int k = 0; k < BITS_PER_STEP; k++) begin
			for (int d = 0; d < DIGITS; d++) begin
				if (bcd_d[d*4 +: 4] >= BCD_LIMIT) begin
					bcd_d[d*4 +: 4] = bcd_d[d*4 +: 4] + BCD_ADJUST;
				end
			end
			bcd_d = {bcd_d[BCD_W-2:0], bin_d[VALUE_W-1]};
			bin_d = {bin_d[VALUE_W-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && !start && (cnt_q == STEP_CNT_W'(STEPS - 1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == STEP_CNT_W'(STEPS - 1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			bin_q <= mag;
			bcd_q <= '0;
		end else if (busy_q) begin
			bin_q <= bin_d;
			bcd_q <= bcd_d;
		end
	end

	assign status.busy = busy_q;
	assign status.done = done_q;
	assign bcd         = bcd_q;

endmodule

FILE: verif/signed_binary_to_decimal_ascii_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the signed 64-bit to decimal ASCII text converter.
module signed_binary_to_decimal_ascii_tb
	import sbda_pkg::*;
();

	localparam int DIRECTED_N      = 19;
	localparam int ITEMS_PER_PHASE = 120;
	localparam int CYCLE_LIMIT     = 400000;
	localparam int SETTLE_CYCLES   = 60;

	typedef struct packed {
		logic [7:0] code;
		logic       last;
	} text_char_t;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      in_valid = 1'b0;
	logic                      in_stall;
	logic signed [VALUE_W-1:0] value = '0;
	logic                      out_valid;
	logic                      out_stall = 1'b0;
	logic [7:0]                char_code;
	logic                      last_char;

	text_char_t  pending_chars[$];
	logic [63:0] dir_value [DIRECTED_N];
	string       dir_text [DIRECTED_N];
	int          send_idle_pct = 0;
	int          recv_idle_pct = 0;
	int          errors = 0;
	int          values_sent = 0;
	int          negatives_sent = 0;
	int          chars_checked = 0;
	int          cycles = 0;

	signed_binary_to_decimal_ascii dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.value     (value),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.char_code (char_code),
		.last_char (last_char)
	);

	always #1 clk = ~clk;

	function automatic void queue_decimal_text(logic [63:0] v);
		logic [63:0] mag;
		logic [3:0]  digit [DIGITS];
		int          n;
		mag = v[63] ? ~v + 64'd1 : v;
		n = 0;
		do begin
			digit[n] = 4'(mag % 64'd10);
			mag = mag / 64'd10;
			n++;
		end while (mag != 64'd0);
		if (v[63])
			pending_chars.push_back(text_char_t'{ASCII_MINUS, 1'b0});
		for (int k = n - 1; k >= 0; k--)
			pending_chars.push_back(text_char_t'{ASCII_ZERO + 8'(digit[k]), k == 0});
	endfunction

	function automatic void queue_typed_text(string s);
		for (int i = 0; i < s.len(); i++)
			pending_chars.push_back(text_char_t'{8'(s[i]), i == s.len() - 1});
	endfunction

	function automatic logic [63:0] pow10(int k);
		logic [63:0] p;
		p = 64'd1;
		repeat (k) p = p * 64'd10;
		return p;
	endfunction

	function automatic logic [63:0] random_value();
		logic [63:0] mag;
		int          kind;
		kind = $urandom_range(4);
		case (kind)
			0: return {$urandom, $urandom};
			1: mag = {$urandom, $urandom} % pow10($urandom_range(1, 19));
			2: mag = pow10($urandom_range(0, 18)) - 64'd1 + 64'($urandom_range(0, 2));
			3: mag = 64'($urandom_range(0, 99));
			default: begin
				if ($urandom_range(1))
					return 64'h7FFF_FFFF_FFFF_FFFF - 64'($urandom_range(3));
				else
					return 64'h8000_0000_0000_0000 + 64'($urandom_range(3));
			end
		endcase
		return $urandom_range(1) ? -mag : mag;
	endfunction

	// hold the beat until taken, then queue its text
	task automatic send_value(input logic [63:0] v, input string typed);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			value <= {$urandom, $urandom};
			@(posedge clk);
		end
		in_valid <= 1'b1;
		value <= v;
		do @(posedge clk); while (in_stall);
		if (typed.len() != 0)
			queue_typed_text(typed);
		else
			queue_decimal_text(v);
		values_sent++;
		if (v[63])
			negatives_sent++;
	endtask

	task automatic drain_text();
		in_valid <= 1'b0;
		while (pending_chars.size() != 0) @(posedge clk);
	endtask

	always @(posedge clk) begin
		text_char_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_chars.size() == 0) begin
				errors++;
				$display("%0t: unexpected char_code %0d last_char %0b, nothing pending",
					$time, char_code, last_char);
			end else begin
				want = pending_chars.pop_front();
				chars_checked++;
				if (char_code !== want.code) begin
					errors++;
					$display("%0t: char_code expected %0d, actual %0d",
						$time, want.code, char_code);
				end
				if (last_char !== want.last) begin
					errors++;
					$display("%0t: last_char expected %0b, actual %0b",
						$time, want.last, last_char);
				end
			end
		end
		out_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		dir_value = '{
			64'd0, 64'd1, -64'sd1, 64'd9, 64'd10, -64'sd10, 64'd99, 64'd100,
			64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0001,
			64'd1000000000000000000, 64'd999999999999999999, -64'sd1000000000000000000,
			64'd1234567890, 64'h0000_0000_FFFF_FFFF, 64'hFFFF_FFFF_0000_0000,
			64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555
		};
		dir_text = '{
			"0", "1", "-1", "9", "10", "-10", "99", "100",
			"9223372036854775807", "-9223372036854775808", "-9223372036854775807",
			"1000000000000000000", "999999999999999999", "-1000000000000000000",
			"1234567890", "4294967295", "-4294967296",
			"", ""
		};
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 16;
		recv_idle_pct = 76;
		for (int i = 0; i < DIRECTED_N; i++)
			send_value(dir_value[i], dir_text[i]);
		drain_text();

		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 16 : (phase == 1) ? 76 : 0;
			recv_idle_pct = (phase == 0) ? 76 : (phase == 1) ? 16 : 0;
			for (int n = 0; n < ITEMS_PER_PHASE; n++)
				send_value(random_value(), "");
			drain_text();
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("Converted %0d values (%0d negative), checked %0d characters",
			values_sent, negatives_sent, chars_checked);
		$display("across sender-heavy, receiver-heavy and back-to-back traffic.");
		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

FILE: sim.f
design/sbda_pkg.sv
design/sbda_dabble.sv
design/signed_binary_to_decimal_ascii.sv
verif/signed_binary_to_decimal_ascii_tb.sv
